/* rtl/fqs_pkg.sv */
// shared types and constants of the fifo queue with search
package fqs_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned DataW        = 32;
  localparam int unsigned CmdW         = 2;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned CountW       = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_SEARCH  = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic             shift;
    logic             cmp;
    logic [DataW-1:0] key;
  } cell_ctrl_t;

endpackage

/* rtl/fqs_if.sv */
// request and response channel interfaces of the fifo queue with search
interface fqs_req_if;
  logic                          valid;
  logic                          ready;
  logic [fqs_pkg::CmdW-1:0]      command;
  logic signed [fqs_pkg::DataW-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

interface fqs_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fqs_pkg::StatusW-1:0]   status;
  logic                          found;
  logic [fqs_pkg::CountW-1:0]    count;
  logic                          is_empty;

  modport source (output valid, output status, output found, output count,
                  output is_empty, input ready);
  modport sink (input valid, input status, input found, input count,
                input is_empty, output ready);
endinterface

/* rtl/fifo_queue_with_search.sv */
// top level of the fifo queue with search: command decode, count and cell row
//
// usage
//   req_i carries one request: a command (enqueue, dequeue, clear, search)
//   and a signed 32-bit value. rsp_o returns exactly one response per
//   request with status, found, the entry count after the command and an
//   empty mark. both channels use valid/ready; a request moves at a clock
//   edge with valid and ready high.
// throughput and search
//   enqueue, dequeue and clear answer in the cycle after acceptance, so one
//   request per cycle is sustained while the receiver keeps up.
//   search of a non-empty queue goes through the S_SEARCH state: every cell compares
//   against the key and registers its hit, then the hits are or-ed into
//   the response. ready stays low while in S_SEARCH.
// stalls
//   the response sits in an output register; a new request is taken while
//   idle and that register is empty or being drained, otherwise ready drops.
// reset
//   rst_ni clears the count and the handshake state; the queue comes up
//   empty. stored values carry no reset, the fill count masks them.
module fifo_queue_with_search #(
  parameter int unsigned DEPTH = fqs_pkg::DepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  fqs_req_if.sink       req_i,
  fqs_rsp_if.source     rsp_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_e;

  state_e state_q;

  logic [CntW-1:0]            count_q, count_d;
  logic                       rsp_valid_q;
  logic [fqs_pkg::StatusW-1:0] rsp_status_q;
  logic                       rsp_found_q;
  logic [fqs_pkg::CountW-1:0] rsp_count_q;
  logic                       rsp_empty_q;

  logic                       accept;
  logic                       is_full, is_none;
  fqs_pkg::cmd_e              cmd;
  fqs_pkg::status_e           status_d;
  fqs_pkg::cell_ctrl_t        ctrl;
  logic                       enq_ok;

  logic [DEPTH-1:0]                      load_vec;
  logic [DEPTH-1:0]                      occ_vec;
  logic [DEPTH-1:0]                      match_vec;
  logic [DEPTH-1:0][fqs_pkg::DataW-1:0]  cell_data;

  // take a request when idle and the output register can accept a response
  assign req_i.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  assign cmd     = fqs_pkg::cmd_e'(req_i.command);
  assign is_full = (count_q == CntW'(DEPTH));
  assign is_none = (count_q == '0);

  // decode of one request into the new count, its status and the cell control
  always_comb begin
    count_d  = count_q;
    status_d = fqs_pkg::ST_OK;
    enq_ok   = 1'b0;
    ctrl     = '{shift: 1'b0, cmp: 1'b0, key: req_i.value};
    case (cmd)
      fqs_pkg::CMD_ENQUEUE: begin
        if (is_full) begin
          status_d = fqs_pkg::ST_FULL;
        end else begin
          enq_ok  = accept;
          count_d = count_q + CntW'(1);
        end
      end
      fqs_pkg::CMD_DEQUEUE: begin
        if (is_none) begin
          status_d = fqs_pkg::ST_EMPTY;
        end else begin
          // oldest entry always lives in cell 0, the row shifts toward it
          ctrl.shift = accept;
          count_d    = count_q - CntW'(1);
        end
      end
      fqs_pkg::CMD_CLEAR: begin
        if (is_none) begin
          status_d = fqs_pkg::ST_EMPTY;
        end else begin
          count_d = '0;
        end
      end
      fqs_pkg::CMD_SEARCH: begin
        if (is_none) begin
          status_d = fqs_pkg::ST_EMPTY;
        end else begin
          ctrl.cmp = accept;
        end
      end
      default: begin
        status_d = fqs_pkg::ST_OK;
      end
    endcase
  end

  // row of entry cells, each handing its value to the cell below on dequeue
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [fqs_pkg::DataW-1:0] next_data;

    assign load_vec[i] = enq_ok && (count_q == CntW'(i));
    assign occ_vec[i]  = (CntW'(i) < count_q);

    if (i == DEPTH - 1) begin : g_last
      assign next_data = cell_data[i];
    end else begin : g_mid
      assign next_data = cell_data[i+1];
    end

    fqs_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .load_i      (load_vec[i]),
      .occ_i       (occ_vec[i]),
      .next_data_i (next_data),
      .data_o      (cell_data[i]),
      .match_o     (match_vec[i])
    );
  end

  // sequencer, count and response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_status_q <= fqs_pkg::ST_OK;
      rsp_found_q  <= 1'b0;
      rsp_count_q  <= '0;
      rsp_empty_q  <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            count_q <= count_d;
            if (ctrl.cmp) begin
              // hits are registered in the cells, the answer is formed in S_SEARCH
              state_q     <= S_SEARCH;
              rsp_valid_q <= 1'b0;
            end else begin
              rsp_valid_q  <= 1'b1;
              rsp_status_q <= status_d;
              rsp_found_q  <= 1'b0;
              rsp_count_q  <= fqs_pkg::CountW'(count_d);
              rsp_empty_q  <= (count_d == '0);
            end
          end else if (rsp_o.ready) begin
            rsp_valid_q <= 1'b0;
          end
        end
        S_SEARCH: begin
          // output register was emptied when the search was taken
          state_q      <= S_IDLE;
          rsp_valid_q  <= 1'b1;
          rsp_status_q <= fqs_pkg::ST_OK;
          rsp_found_q  <= |match_vec;
          rsp_count_q  <= fqs_pkg::CountW'(count_q);
          rsp_empty_q  <= 1'b0;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.status   = rsp_status_q;
  assign rsp_o.found    = rsp_found_q;
  assign rsp_o.count    = rsp_count_q;
  assign rsp_o.is_empty = rsp_empty_q;

endmodule

/* rtl/fqs_cell.sv */
// one entry cell of the queue row: holds a value, shifts, compares
module fqs_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fqs_pkg::cell_ctrl_t        ctrl_i,
  input  logic                       load_i,
  input  logic                       occ_i,
  input  logic [fqs_pkg::DataW-1:0]  next_data_i,
  output logic [fqs_pkg::DataW-1:0]  data_o,
  output logic                       match_o
);

  logic [fqs_pkg::DataW-1:0] data_q, data_d;
  logic                      match_q;

  always_comb begin
    data_d = data_q;
    if (load_i) begin
      data_d = ctrl_i.key;
    end else if (ctrl_i.shift) begin
      data_d = next_data_i;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.cmp) begin
      match_q <= occ_i && (data_q == ctrl_i.key);
    end
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

/* rtl/fqs_checker.sv */
// port-level checks of the fifo queue with search and their bind
module fqs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [fqs_pkg::StatusW-1:0]   rsp_status_i,
  input logic                          rsp_found_i,
  input logic [fqs_pkg::CountW-1:0]    rsp_count_i,
  input logic                          rsp_empty_i
);

  // a pending response is held until taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_count_i))
    else $error("response dropped while stalled");

  // empty mark agrees with the count
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_empty_i == (rsp_count_i == '0)))
    else $error("empty mark disagrees with count");

  // a hit only comes from a successful search of a non-empty queue
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_found_i |-> (rsp_status_i == fqs_pkg::ST_OK) && !rsp_empty_i)
    else $error("found set on a failed or empty response");

  // an empty status leaves the queue empty
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == fqs_pkg::ST_EMPTY) |-> rsp_empty_i)
    else $error("empty status with entries held");

endmodule

bind fifo_queue_with_search fqs_checker u_fqs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_found_i  (rsp_o.found),
  .rsp_count_i  (rsp_o.count),
  .rsp_empty_i  (rsp_o.is_empty)
);

/* tb/testbench.sv */
// self-checking testbench of the fifo queue with search, directed table then random traffic
`timescale 1ns / 1ps

module testbench;
  import fqs_pkg::*;

  localparam int unsigned Depth       = DepthDefault;
  localparam int          RandomItems = 1924;
  localparam int          StallLimit  = 5000;   // cycles with no request moving on either side
  localparam int          TailCycles  = 10;     // search answers after the S_SEARCH state
  localparam int          ShownErrors = 10;

  // one response as the block should give it
  typedef struct packed {
    status_e            status;
    logic               found;
    logic [CountW-1:0]  count;
    logic               is_empty;
  } answer_t;

  // one row of the directed table; typed rows carry their answer
  typedef struct {
    cmd_e              command;
    logic [DataW-1:0]  value;
    bit                typed;
    answer_t           answer;
  } plan_row_t;

  // traffic mixes of the random part
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN,
    MIX_PROBE
  } mix_e;

  logic clk_i;
  logic rst_ni;

  fqs_req_if req ();
  fqs_rsp_if rsp ();

  fifo_queue_with_search #(
    .DEPTH (Depth)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // free-running clock, 10 ns period
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // mirror of the queue: ring of cells, oldest slot and fill level
  logic [DataW-1:0]          mirror_cells [Depth];
  int unsigned               mirror_head;
  int unsigned               mirror_fill;

  answer_t                   pending_answers [$];   // answers owed by the block, oldest first
  int                        fail_count;
  int                        stall_cycles;
  bit                        steady_run;            // both sides keep going, no idling
  bit                        row_typed;             // request on the bus carries a typed answer
  answer_t                   row_answer;

  // apply one command to the mirror and work out its answer
  task automatic mirror_queue_step(input cmd_e cmd, input logic [DataW-1:0] key,
                                   output answer_t ans);
    status_e     st;
    logic        hit;
    int unsigned k;
    st  = ST_OK;
    hit = 1'b0;
    case (cmd)
      CMD_ENQUEUE: begin
        if (mirror_fill >= Depth) begin
          st = ST_FULL;
        end else begin
          mirror_cells[(mirror_head + mirror_fill) % Depth] = key;
          mirror_fill++;
        end
      end
      CMD_DEQUEUE: begin
        if (mirror_fill == 0) begin
          st = ST_EMPTY;
        end else begin
          mirror_head = (mirror_head + 1) % Depth;
          mirror_fill--;
        end
      end
      CMD_CLEAR: begin
        if (mirror_fill == 0) begin
          st = ST_EMPTY;
        end else begin
          mirror_fill = 0;
          mirror_head = 0;
        end
      end
      default: begin
        // search: full 32-bit pattern compare over the live entries only
        if (mirror_fill == 0) begin
          st = ST_EMPTY;
        end else begin
          for (k = 0; k < mirror_fill; k++) begin
            if (mirror_cells[(mirror_head + k) % Depth] == key) hit = 1'b1;
          end
        end
      end
    endcase
    ans.status   = st;
    ans.found    = hit;
    ans.count    = CountW'(mirror_fill);
    ans.is_empty = (mirror_fill == 0);
  endtask

  // count a failure, print only the first few
  task automatic note_mismatch(input string msg);
    fail_count++;
    if (fail_count <= ShownErrors) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // present one request at a falling edge and hold it until accepted
  task automatic send_request(input cmd_e cmd, input logic [DataW-1:0] val);
    // random idle gap before the request, skipped in the steady stretch
    while (!steady_run && $urandom_range(0, 99) < 31) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid   <= 1'b1;
    req.command <= cmd;
    req.value   <= val;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // drop valid and hold off until every owed answer has come back
  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk_i);
  endtask

  // response side: ready is set at random at falling edges, held high in the steady stretch
  always @(negedge clk_i) begin
    rsp.ready <= steady_run || ($urandom_range(0, 99) >= 31);
  end

  // checker and predictor, both at the rising edge
  always @(posedge clk_i) begin
    answer_t got;
    answer_t want;
    if (rst_ni) begin
      // response first: the answer to a request accepted now cannot show up at this edge
      if (rsp.valid && rsp.ready) begin
        got.status   = status_e'(rsp.status);
        got.found    = rsp.found;
        got.count    = rsp.count;
        got.is_empty = rsp.is_empty;
        if (pending_answers.size() == 0) begin
          note_mismatch($sformatf("response with none owed: status=%0d found=%0d count=%0d empty=%0d",
                                  got.status, got.found, got.count, got.is_empty));
        end else begin
          want = pending_answers.pop_front();
          if (got.status !== want.status || got.found !== want.found ||
              got.count !== want.count || got.is_empty !== want.is_empty) begin
            note_mismatch($sformatf({"expected status=%0d found=%0d count=%0d empty=%0d, ",
                                     "got status=%0d found=%0d count=%0d empty=%0d"},
                                    want.status, want.found, want.count, want.is_empty,
                                    got.status, got.found, got.count, got.is_empty));
          end
        end
      end
      // accepted request: the mirror always advances, typed table rows override its answer
      if (req.valid && req.ready) begin
        mirror_queue_step(cmd_e'(req.command), req.value, want);
        if (row_typed) want = row_answer;
        pending_answers.push_back(want);
      end
    end
  end

  // watchdog: too long without any request or response moving ends the run
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("[fifo_queue_with_search] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    plan_row_t        plan [$];
    logic [DataW-1:0] value_pool [8];
    mix_e             mix;
    cmd_e             cmd;
    logic [DataW-1:0] val;
    int               n;
    int               roll;
    int               enq_lim;
    int               deq_lim;
    int               srch_lim;

    // every input known from time zero, reset held
    rst_ni       = 1'b0;
    req.valid    = 1'b0;
    req.command  = CMD_ENQUEUE;
    req.value    = '0;
    rsp.ready    = 1'b0;
    steady_run   = 1'b0;
    row_typed    = 1'b0;
    row_answer   = '0;
    fail_count   = 0;
    stall_cycles = 0;
    mirror_head  = 0;
    mirror_fill  = 0;
    for (n = 0; n < Depth; n++) mirror_cells[n] = '0;

    value_pool = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                   32'h0000_0001, 32'h5a5a_5a5a, 32'ha5a5_a5a5, 32'h1234_5678};

    // empty-queue corner cases: dequeue, clear and search all flag empty
    plan.push_back('{CMD_DEQUEUE, 32'h0000_0000, 1'b1, '{ST_EMPTY, 1'b0, 5'd0, 1'b1}});
    plan.push_back('{CMD_CLEAR,   32'hffff_ffff, 1'b1, '{ST_EMPTY, 1'b0, 5'd0, 1'b1}});
    plan.push_back('{CMD_SEARCH,  32'h0000_0000, 1'b1, '{ST_EMPTY, 1'b0, 5'd0, 1'b1}});
    // fill to the brim, extremes of the value first
    plan.push_back('{CMD_ENQUEUE, 32'h8000_0000, 1'b1, '{ST_OK, 1'b0, 5'd1, 1'b0}});
    plan.push_back('{CMD_ENQUEUE, 32'h7fff_ffff, 1'b1, '{ST_OK, 1'b0, 5'd2, 1'b0}});
    plan.push_back('{CMD_ENQUEUE, 32'h0000_0000, 1'b1, '{ST_OK, 1'b0, 5'd3, 1'b0}});
    plan.push_back('{CMD_ENQUEUE, 32'hffff_ffff, 1'b1, '{ST_OK, 1'b0, 5'd4, 1'b0}});
    plan.push_back('{CMD_ENQUEUE, 32'h0000_0001, 1'b1, '{ST_OK, 1'b0, 5'd5, 1'b0}});
    plan.push_back('{CMD_ENQUEUE, 32'hffff_fffe, 1'b1, '{ST_OK, 1'b0, 5'd6, 1'b0}});
    plan.push_back('{CMD_ENQUEUE, 32'h5555_5555, 1'b1, '{ST_OK, 1'b0, 5'd7, 1'b0}});
    plan.push_back('{CMD_ENQUEUE, 32'haaaa_aaaa, 1'b1, '{ST_OK, 1'b0, 5'd8, 1'b0}});
    plan.push_back('{CMD_ENQUEUE, 32'h5a5a_5a5a, 1'b1, '{ST_OK, 1'b0, 5'd9, 1'b0}});
    plan.push_back('{CMD_ENQUEUE, 32'ha5a5_a5a5, 1'b1, '{ST_OK, 1'b0, 5'd10, 1'b0}});
    plan.push_back('{CMD_ENQUEUE, 32'h1234_5678, 1'b1, '{ST_OK, 1'b0, 5'd11, 1'b0}});
    plan.push_back('{CMD_ENQUEUE, 32'hedcb_a987, 1'b1, '{ST_OK, 1'b0, 5'd12, 1'b0}});
    plan.push_back('{CMD_ENQUEUE, 32'h0000_ffff, 1'b1, '{ST_OK, 1'b0, 5'd13, 1'b0}});
    plan.push_back('{CMD_ENQUEUE, 32'hffff_0000, 1'b1, '{ST_OK, 1'b0, 5'd14, 1'b0}});
    plan.push_back('{CMD_ENQUEUE, 32'h0000_0002, 1'b1, '{ST_OK, 1'b0, 5'd15, 1'b0}});
    plan.push_back('{CMD_ENQUEUE, 32'h4000_0000, 1'b1, '{ST_OK, 1'b0, 5'd16, 1'b0}});
    // enqueue into a full queue is refused
    plan.push_back('{CMD_ENQUEUE, 32'h0bad_0bad, 1'b1, '{ST_FULL, 1'b0, 5'd16, 1'b0}});
    plan.push_back('{CMD_SEARCH,  32'h8000_0000, 1'b1, '{ST_OK, 1'b1, 5'd16, 1'b0}});
    plan.push_back('{CMD_DEQUEUE, 32'h0000_0000, 1'b1, '{ST_OK, 1'b0, 5'd15, 1'b0}});
    // the oldest entry is gone, the newest one is still there
    plan.push_back('{CMD_SEARCH,  32'h8000_0000, 1'b0, '0});
    plan.push_back('{CMD_SEARCH,  32'h4000_0000, 1'b0, '0});
    // clear of a filled queue, then search of the empty one
    plan.push_back('{CMD_CLEAR,   32'h0000_0000, 1'b1, '{ST_OK, 1'b0, 5'd0, 1'b1}});
    plan.push_back('{CMD_SEARCH,  32'h0000_0000, 1'b1, '{ST_EMPTY, 1'b0, 5'd0, 1'b1}});

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (plan[i]) begin
      row_typed  = plan[i].typed;
      row_answer = plan[i].answer;
      send_request(plan[i].command, plan[i].value);
    end
    row_typed = 1'b0;

    // let the block settle before the random part
    wait_drained();

    // random traffic in blocks of one mix each, so the fill level wanders over its range
    mix = MIX_FILL;
    for (n = 0; n < RandomItems; n++) begin
      if (n % 64 == 0) mix = mix_e'($urandom_range(0, 3));
      steady_run = (n >= 700 && n < 1000);
      if (n == 1300) wait_drained();

      case (mix)
        MIX_FILL:  begin enq_lim = 65; deq_lim = 80; srch_lim = 97; end
        MIX_DRAIN: begin enq_lim = 25; deq_lim = 70; srch_lim = 98; end
        MIX_EVEN:  begin enq_lim = 40; deq_lim = 70; srch_lim = 96; end
        default:   begin enq_lim = 30; deq_lim = 45; srch_lim = 98; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < enq_lim)       cmd = CMD_ENQUEUE;
      else if (roll < deq_lim)  cmd = CMD_DEQUEUE;
      else if (roll < srch_lim) cmd = CMD_SEARCH;
      else                      cmd = CMD_CLEAR;

      // searches often look for a live entry; pool values make duplicates and near misses
      roll = $urandom_range(0, 9);
      if (cmd == CMD_SEARCH && mirror_fill != 0 && roll < 5)
        val = mirror_cells[(mirror_head + $urandom_range(0, mirror_fill - 1)) % Depth];
      else if (roll < 7)
        val = value_pool[$urandom_range(0, 7)];
      else
        val = $urandom();

      send_request(cmd, val);
    end
    steady_run = 1'b0;

    // wind down: all answers in, then a wait of TailCycles for anything stray
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (pending_answers.size() != 0)
      note_mismatch($sformatf("%0d answers never arrived", pending_answers.size()));

    if (fail_count == 0) begin
      $display("[fifo_queue_with_search] OK");
    end else begin
      $display("[fifo_queue_with_search] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/fqs_pkg.sv
rtl/fqs_if.sv
rtl/fqs_cell.sv
rtl/fifo_queue_with_search.sv
rtl/fqs_checker.sv
tb/testbench.sv
